// File: sv/minv_pkg.sv
// Shared constants for the 3x3 matrix inverse block.
`timescale 1ns / 1ps
package minv_pkg;
  localparam int ElemWidthDef = 8;
  localparam int FracBitsDef  = 16;
  localparam int DetWidth     = 25;
  localparam int InvWidth     = 32;
  localparam int Lanes        = 9;
endpackage

// File: sv/minv_if.sv
// Handshake channels for the matrix input item and the inverse result item.
`timescale 1ns / 1ps
interface minv_in_if #(
  parameter int ELEM_WIDTH = 8
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface

interface minv_out_if;
  import minv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [DetWidth-1:0] determinant;
  logic                       invertible;
  logic signed [InvWidth-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  modport source (output valid, determinant, invertible,
                  inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
                  input ready);
  modport sink (input valid, determinant, invertible,
                inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
                output ready);
endinterface

// File: sv/minv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module minv_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 27
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);
  // nq holds the numerator bits not yet used on the left and quotient bits on the right.
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NUM_W-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[k]  <= {nq_in[NUM_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NUM_W-1];
endmodule

// File: sv/matrix_inverse_3x3.sv
// Top level of the 3x3 integer matrix inverse by adjugate and pipelined division.
`timescale 1ns / 1ps
//
//  Channel | Modport       | Carries
//  --------+---------------+--------------------------------------------------
//  inp_i   | minv_in sink  | one item: nine signed matrix elements a00..a22
//  res_o   | minv_out src  | one item: determinant, invertible, inv00..inv22
//
// One item enters per cycle and one result leaves per cycle when the sink keeps up.
// The divider is pipelined in NW stages, one quotient bit per stage,
// with NW = 2*ELEM_WIDTH + 1 + FRAC_BITS.
// Reset clears only the valid bits; data registers are left as they are.
// A stall on res_o freezes every stage at once, so no item is lost or repeated,
// and inp_i.ready drops in the same cycle.
module matrix_inverse_3x3
  import minv_pkg::*;
#(
  parameter int ELEM_WIDTH = ElemWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  minv_in_if.sink    inp_i,
  minv_out_if.source res_o
);
  // Widths of the intermediate values.
  localparam int PW  = 2 * ELEM_WIDTH;      // element product
  localparam int AW  = 2 * ELEM_WIDTH + 1;  // adjugate entry
  localparam int DW  = 3 * ELEM_WIDTH + 3;  // determinant
  localparam int NW  = AW + FRAC_BITS;      // scaled numerator and quotient
  localparam int XW  = ((NW > InvWidth) ? NW : InvWidth) + 1;
  localparam int EW  = (DW > DetWidth) ? DW : DetWidth;
  localparam int DLY = NW;                  // side data delay matching the divider

  localparam logic [XW-1:0] PosLim = XW'((64'd1 << (InvWidth - 1)) - 64'd1);
  localparam logic [XW-1:0] NegLim = XW'(64'd1 << (InvWidth - 1));

  // The whole pipeline advances together unless the output item waits.
  logic en;
  assign en          = !res_o.valid || res_o.ready;
  assign inp_i.ready = en;

  // Stage 1: the eighteen element products of the cofactors.
  logic                     v1_q;
  logic signed [ELEM_WIDTH-1:0] r0_q [3];
  logic signed [PW-1:0]     pa_q [Lanes];
  logic signed [PW-1:0]     pb_q [Lanes];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q[0] <= inp_i.a00;
      r0_q[1] <= inp_i.a01;
      r0_q[2] <= inp_i.a02;
      pa_q[0] <= inp_i.a11 * inp_i.a22;  pb_q[0] <= inp_i.a12 * inp_i.a21;
      pa_q[1] <= inp_i.a02 * inp_i.a21;  pb_q[1] <= inp_i.a01 * inp_i.a22;
      pa_q[2] <= inp_i.a01 * inp_i.a12;  pb_q[2] <= inp_i.a02 * inp_i.a11;
      pa_q[3] <= inp_i.a12 * inp_i.a20;  pb_q[3] <= inp_i.a10 * inp_i.a22;
      pa_q[4] <= inp_i.a00 * inp_i.a22;  pb_q[4] <= inp_i.a02 * inp_i.a20;
      pa_q[5] <= inp_i.a02 * inp_i.a10;  pb_q[5] <= inp_i.a00 * inp_i.a12;
      pa_q[6] <= inp_i.a10 * inp_i.a21;  pb_q[6] <= inp_i.a11 * inp_i.a20;
      pa_q[7] <= inp_i.a01 * inp_i.a20;  pb_q[7] <= inp_i.a00 * inp_i.a21;
      pa_q[8] <= inp_i.a00 * inp_i.a11;  pb_q[8] <= inp_i.a01 * inp_i.a10;
    end
  end

  // Stage 2: adjugate entries, already in transposed order with signs applied.
  logic                     v2_q;
  logic signed [ELEM_WIDTH-1:0] r0b_q [3];
  logic signed [AW-1:0]     adj_q [Lanes];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0b_q <= r0_q;
      for (int i = 0; i < Lanes; i++) begin
        adj_q[i] <= AW'(pa_q[i]) - AW'(pb_q[i]);
      end
    end
  end

  // Stage 3: the row-0 expansion terms of the determinant.
  logic                 v3_q;
  logic signed [DW-1:0] dp_q [3];
  logic signed [AW-1:0] adjb_q [Lanes];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q[0] <= DW'(r0b_q[0] * adj_q[0]);
      dp_q[1] <= DW'(r0b_q[1] * adj_q[3]);
      dp_q[2] <= DW'(r0b_q[2] * adj_q[6]);
      adjb_q  <= adj_q;
    end
  end

  // Stage 4: determinant sum, adjugate magnitudes and signs.
  logic                 v4_q;
  logic signed [DW-1:0] det4_q;
  logic [AW-1:0]        amag_q [Lanes];
  logic [Lanes-1:0]     asgn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det4_q <= dp_q[0] + dp_q[1] + dp_q[2];
      for (int i = 0; i < Lanes; i++) begin
        asgn_q[i] <= adjb_q[i][AW-1];
        amag_q[i] <= adjb_q[i][AW-1] ? AW'(-adjb_q[i]) : AW'(adjb_q[i]);
      end
    end
  end

  // Stage 5: determinant magnitude, result signs and the singular flag.
  logic                 v5_q;
  logic signed [DW-1:0] det5_q;
  logic [DW-1:0]        dmag_q;
  logic                 nz5_q;
  logic [Lanes-1:0]     neg5_q;
  logic [AW-1:0]        amagb_q [Lanes];

  always_ff @(posedge clk_i) begin
    if (en) begin
      det5_q  <= det4_q;
      dmag_q  <= det4_q[DW-1] ? DW'(-det4_q) : DW'(det4_q);
      nz5_q   <= (det4_q != '0);
      neg5_q  <= asgn_q ^ {Lanes{det4_q[DW-1]}};
      amagb_q <= amag_q;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= inp_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Nine divider lanes: (|adj| << FRAC_BITS) / |det|.
  logic [NW-1:0] quo [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    minv_div #(
      .NUM_W(NW),
      .DEN_W(DW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({amagb_q[l], {FRAC_BITS{1'b0}}}),
      .den_i (dmag_q),
      .quo_o (quo[l])
    );
  end

  // Side data travels in a delay line alongside the divider stages.
  logic                 vd_q   [DLY];
  logic signed [DW-1:0] detd_q [DLY];
  logic                 nzd_q  [DLY];
  logic [Lanes-1:0]     negd_q [DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DLY; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (en) begin
      vd_q[0] <= v5_q;
      for (int k = 1; k < DLY; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      detd_q[0] <= det5_q;
      nzd_q[0]  <= nz5_q;
      negd_q[0] <= neg5_q;
      for (int k = 1; k < DLY; k++) begin
        detd_q[k] <= detd_q[k-1];
        nzd_q[k]  <= nzd_q[k-1];
        negd_q[k] <= negd_q[k-1];
      end
    end
  end

  // Sign, saturate to the signed 32-bit range, and clear on a singular matrix.
  function automatic logic [InvWidth-1:0] fix_result(input logic [NW-1:0] q,
                                                     input logic neg, input logic nz);
    logic [XW-1:0] qx;
    logic [XW-1:0] r;
    begin
      qx = XW'(q);
      if (neg) begin
        r = (qx > NegLim) ? NegLim : qx;
        r = -r;
      end else begin
        r = (qx > PosLim) ? PosLim : qx;
      end
      fix_result = nz ? r[InvWidth-1:0] : '0;
    end
  endfunction

  // Output register stage.
  logic                       vo_q;
  logic signed [DetWidth-1:0] det_q;
  logic                       inv_ok_q;
  logic [InvWidth-1:0]        res_q [Lanes];
  logic signed [EW-1:0]       det_ext;

  assign det_ext = EW'(detd_q[DLY-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd_q[DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q    <= det_ext[DetWidth-1:0];
      inv_ok_q <= nzd_q[DLY-1];
      for (int i = 0; i < Lanes; i++) begin
        res_q[i] <= fix_result(quo[i], negd_q[DLY-1][i], nzd_q[DLY-1]);
      end
    end
  end

  assign res_o.valid       = vo_q;
  assign res_o.determinant = det_q;
  assign res_o.invertible  = inv_ok_q;
  assign res_o.inv00       = res_q[0];
  assign res_o.inv01       = res_q[1];
  assign res_o.inv02       = res_q[2];
  assign res_o.inv10       = res_q[3];
  assign res_o.inv11       = res_q[4];
  assign res_o.inv12       = res_q[5];
  assign res_o.inv20       = res_q[6];
  assign res_o.inv21       = res_q[7];
  assign res_o.inv22       = res_q[8];
endmodule

// File: sv/minv_chk.sv
// Port-level checker for the matrix inverse block, bound to the top level.
`timescale 1ns / 1ps
module minv_chk
  import minv_pkg::*;
#(
  parameter int ELEM_WIDTH = ElemWidthDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [DetWidth-1:0] det_i,
  input logic                       ok_i,
  input logic signed [InvWidth-1:0] inv00_i,
  input logic signed [InvWidth-1:0] inv11_i,
  input logic signed [InvWidth-1:0] inv22_i
);
  // A waiting result item stays offered.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // The input side is held off whenever the output stalls.
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // A singular matrix gives a zero determinant and zero inv00, inv11 and inv22.
  a_sing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> det_i == '0 && inv00_i == '0 && inv11_i == '0 && inv22_i == '0)
    else $error("singular result not cleared");

  // At narrow elements the flag matches the determinant field.
  a_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ELEM_WIDTH <= 7) && out_valid_i |-> ok_i == (det_i != '0))
    else $error("invertible flag disagrees with determinant");
endmodule

bind matrix_inverse_3x3 minv_chk #(
  .ELEM_WIDTH(ELEM_WIDTH)
) u_minv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (inp_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .det_i       (res_o.determinant),
  .ok_i        (res_o.invertible),
  .inv00_i     (res_o.inv00),
  .inv11_i     (res_o.inv11),
  .inv22_i     (res_o.inv22)
);

// File: dv/tb.sv
// Testbench for the 3x3 matrix inverse: directed table, then random matrices, checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import minv_pkg::*;

  // One matrix as it enters, and one inverse result as it should leave.
  typedef struct {
    logic signed [7:0] el [9];
  } matrix_t;

  typedef struct {
    logic signed [DetWidth-1:0] det;
    logic                       inv_ok;
    logic signed [InvWidth-1:0] inv [9];
  } inverse_t;

  // A row of the directed table: the matrix and, where it is obvious, the result.
  typedef struct {
    matrix_t  mat;
    bit       typed;
    inverse_t res;
  } vector_t;

  logic clk_i;
  logic rst_ni;

  minv_in_if #(.ELEM_WIDTH(8)) inp ();
  minv_out_if                  res ();

  matrix_inverse_3x3 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inp_i  (inp.sink),
    .res_o  (res.source)
  );

  inverse_t pending_q[$];
  int       errors;
  bit       drive_done;
  vector_t  table_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run: far above the slowest correct run.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  // Quotient of adj * 2^16 by det, truncated toward zero, saturated to 32 bits.
  function automatic logic signed [InvWidth-1:0] fixed_quotient(longint num, longint den);
    longint unsigned mag_n, mag_d, q;
    bit              neg;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    neg   = (num < 0) != (den < 0);
    q     = (mag_n << FracBitsDef) / mag_d;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return InvWidth'(-$signed(q));
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return q[31:0];
  endfunction

  // Determinant by expansion along row 0 and the adjugate, then the scaled quotients.
  function automatic inverse_t invert_matrix(matrix_t mx);
    longint   m [9];
    longint   adj [9];
    longint   det;
    inverse_t r;
    for (int i = 0; i < 9; i++) m[i] = mx.el[i];
    adj[0] =   m[4] * m[8] - m[5] * m[7];
    adj[1] = -(m[1] * m[8] - m[2] * m[7]);
    adj[2] =   m[1] * m[5] - m[2] * m[4];
    adj[3] = -(m[3] * m[8] - m[5] * m[6]);
    adj[4] =   m[0] * m[8] - m[2] * m[6];
    adj[5] = -(m[0] * m[5] - m[2] * m[3]);
    adj[6] =   m[3] * m[7] - m[4] * m[6];
    adj[7] = -(m[0] * m[7] - m[1] * m[6]);
    adj[8] =   m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    r.det    = det[DetWidth-1:0];
    r.inv_ok = (det != 0);
    for (int i = 0; i < 9; i++) r.inv[i] = (det != 0) ? fixed_quotient(adj[i], det) : '0;
    return r;
  endfunction

  function automatic matrix_t make_matrix(int v0, int v1, int v2, int v3, int v4,
                                          int v5, int v6, int v7, int v8);
    matrix_t mx;
    mx.el[0] = 8'(v0); mx.el[1] = 8'(v1); mx.el[2] = 8'(v2);
    mx.el[3] = 8'(v3); mx.el[4] = 8'(v4); mx.el[5] = 8'(v5);
    mx.el[6] = 8'(v6); mx.el[7] = 8'(v7); mx.el[8] = 8'(v8);
    return mx;
  endfunction

  // Random matrix: mostly full range, sometimes small elements, extreme values or a copied row
  // so that singular matrices and large quotients both show up.
  function automatic matrix_t random_matrix();
    matrix_t mx;
    int      mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 6) mx.el[i] = 8'($urandom);
      else if (mode < 8) mx.el[i] = 8'($signed($urandom_range(0, 6)) - 3);
      else mx.el[i] = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
    end
    if (mode == 5) begin
      for (int c = 0; c < 3; c++) mx.el[6 + c] = mx.el[c];
    end
    return mx;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item was taken.
  // Valid stays high across back-to-back items and drops only for an idle gap.
  task automatic send_matrix(matrix_t mx);
    int idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      inp.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    inp.a00 <= mx.el[0]; inp.a01 <= mx.el[1]; inp.a02 <= mx.el[2];
    inp.a10 <= mx.el[3]; inp.a11 <= mx.el[4]; inp.a12 <= mx.el[5];
    inp.a20 <= mx.el[6]; inp.a21 <= mx.el[7]; inp.a22 <= mx.el[8];
    inp.valid <= 1'b1;
    do @(posedge clk_i); while (!inp.ready);
    pending_q.push_back(invert_matrix(mx));
    @(negedge clk_i);
  endtask

  task automatic compare_field(string name, longint got, longint want);
    if (got != want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result monitor: every accepted result is checked against the oldest expectation.
  initial begin
    inverse_t want;
    logic signed [InvWidth-1:0] got [9];
    forever begin
      @(posedge clk_i);
      if (rst_ni && res.valid && res.ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result with no matrix outstanding", $time);
        end else begin
          want = pending_q.pop_front();
          got = '{res.inv00, res.inv01, res.inv02, res.inv10, res.inv11,
                  res.inv12, res.inv20, res.inv21, res.inv22};
          compare_field("determinant", res.determinant, want.det);
          compare_field("invertible", res.invertible, want.inv_ok);
          for (int i = 0; i < 9; i++)
            compare_field($sformatf("inv%0d%0d", i / 3, i % 3), got[i], want.inv[i]);
        end
      end
    end
  end

  // Sink stall: a fresh random wait after a result is offered, none in alternate windows of simulation time.
  initial begin
    int hold;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (res.valid) hold = ($time / 2000 % 2) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    vector_t row;
    int      drain;
    errors      = 0;
    drive_done  = 1'b0;
    rst_ni      = 1'b0;
    inp.valid   = 1'b0;
    {inp.a00, inp.a01, inp.a02, inp.a10, inp.a11, inp.a12, inp.a20, inp.a21, inp.a22} = '0;

    // Directed rows. The all-zero and copied-row matrices are singular, so the
    // result is known outright; the identity inverts to 1.0 on the diagonal.
    row = '{default: '0};
    row.mat = make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1'b1; row.res.det = 0; row.res.inv_ok = 0;
    row.res.inv = '{default: 0};
    table_rows.push_back(row);
    row.mat = make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
    row.res.det = 1; row.res.inv_ok = 1;
    row.res.inv = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    table_rows.push_back(row);
    row.mat = make_matrix(-128, -128, -128, -128, -128, -128, -128, -128, -128);
    row.res.det = 0; row.res.inv_ok = 0; row.res.inv = '{default: 0};
    table_rows.push_back(row);
    row.mat = make_matrix(127, 127, 127, 127, 127, 127, 127, 127, 127);
    table_rows.push_back(row);
    row.typed = 1'b0;
    row.mat = make_matrix(-128, 127, 127, 127, -128, 127, 127, 127, -128);
    table_rows.push_back(row);
    row.mat = make_matrix(-128, 0, 0, 0, -128, 0, 0, 0, -128);
    table_rows.push_back(row);
    row.mat = make_matrix(127, 0, 0, 0, 127, 0, 0, 0, 127);
    table_rows.push_back(row);
    row.mat = make_matrix(127, -128, 0, 127, 127, -128, -128, 127, 127);
    table_rows.push_back(row);
    row.mat = make_matrix(1, 2, 3, 0, 1, 4, 5, 6, 0);
    table_rows.push_back(row);
    row.mat = make_matrix(0, 1, 0, 0, 0, 1, 1, 0, 0);
    table_rows.push_back(row);
    row.mat = make_matrix(2, 0, 0, 0, -3, 0, 0, 0, 7);
    table_rows.push_back(row);
    row.mat = make_matrix(1, 2, 3, 4, 5, 6, 7, 8, 9);
    table_rows.push_back(row);
    row.mat = make_matrix(-1, -1, -1, -1, 0, 0, 0, -1, 0);
    table_rows.push_back(row);
    row.mat = make_matrix(1, 127, 1, 0, 1, 127, 0, 0, 1);
    table_rows.push_back(row);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (table_rows[i]) begin
      send_matrix(table_rows[i].mat);
      // The typed result replaces the predicted one for the obvious rows.
      if (table_rows[i].typed) pending_q[pending_q.size() - 1] = table_rows[i].res;
    end
    inp.valid <= 1'b0;

    // Let the pipeline drain fully once before the random part.
    while (pending_q.size() != 0) @(negedge clk_i);

    for (int n = 0; n < 1340; n++) send_matrix(random_matrix());
    inp.valid <= 1'b0;

    drive_done = 1'b1;
    drain = 0;
    while (pending_q.size() != 0 && drain < 20000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_q.size() != 0) $display("%0t: %0d results never arrived", $time,
                                          pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: files.f
sv/minv_pkg.sv
sv/minv_if.sv
sv/minv_div.sv
sv/matrix_inverse_3x3.sv
sv/minv_chk.sv
dv/tb.sv
